[hdl/lcs_pkg.sv]
// Shared constants and types for the longest common substring core.
`default_nettype none
package lcs_pkg;

   localparam int MAX_LEN       = 1024;
   localparam int IDX_W         = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W         = $clog2(MAX_LEN + 1);
   localparam int SYM_W         = 8;
   localparam int MATCH_LEN_W   = 11;
   localparam int MATCH_START_W = 10;
   localparam int RSP_DATA_W    = ((MATCH_LEN_W + MATCH_START_W + 7) / 8) * 8;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_COMPARE = 1'b1
   } op_type;

   // one row of the DP as it travels down the cell chain
   typedef struct packed {
      logic             valid;
      logic             proc;   // row is evaluated (not past the row limit)
      logic             last;   // final row of the comparison: clear runs behind it
      logic             ovf;    // overflow flag snapshot, meaningful on last
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] diag;   // previous-row run of the left neighbor column
      logic [LEN_W-1:0] best;   // running row maximum
   } wave_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] idx;
      logic [SYM_W-1:0] sym;
   } store_wr_type;

endpackage
`default_nettype wire

[hdl/lcs_cell.sv]
// One column cell: holds a second-string byte and its run length, forwards the row wave.
`default_nettype none
module lcs_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  advance,
   input  wire [lcs_pkg::IDX_W-1:0] cell_index,
   input  wire [lcs_pkg::LEN_W-1:0] str_len,
   input  lcs_pkg::store_wr_type store_wr,
   input  lcs_pkg::wave_type     wave_i,
   output lcs_pkg::wave_type     wave_o
);
   import lcs_pkg::*;

   logic [SYM_W-1:0] char_ff;
   logic [LEN_W-1:0] run_ff;
   logic [LEN_W-1:0] run_in;
   logic [LEN_W-1:0] run_new;
   wave_type         wave_ff;
   wave_type         wave_in;
   logic             active;

   always_comb begin
      active  = LEN_W'(cell_index) < str_len;
      run_new = (char_ff == wave_i.sym) ? wave_i.diag + 1'b1 : '0;
      wave_in      = wave_i;
      wave_in.diag = run_ff;   // neighbor sees this column's previous-row run
      run_in       = run_ff;
      if (wave_i.valid && wave_i.proc && active) begin
         run_in = run_new;
         if (run_new > wave_i.best) begin
            wave_in.best = run_new;
         end
      end
      if (wave_i.valid && wave_i.last) begin
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff.valid <= 1'b0;
         run_ff        <= '0;
      end else if (advance) begin
         wave_ff <= wave_in;
         run_ff  <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr.we && (store_wr.idx == cell_index)) begin
         char_ff <= store_wr.sym;
      end
   end

   assign wave_o = wave_ff;

endmodule
`default_nettype wire

[hdl/lcs_front.sv]
// Input stage: holds one beat, writes the second string, launches row waves.
`default_nettype none
module lcs_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  lcs_pkg::op_type       req_op,
   input  wire [lcs_pkg::SYM_W-1:0] req_sym,
   input  wire                  req_last,
   input  wire                  advance,
   input  wire                  chain_exit,
   output lcs_pkg::wave_type     wave_o,
   output lcs_pkg::store_wr_type store_wr,
   output logic [lcs_pkg::LEN_W-1:0] str_len
);
   import lcs_pkg::*;

   logic             in_full_ff, in_full_in;
   op_type           in_op_ff;
   logic [SYM_W-1:0] in_sym_ff;
   logic             in_last_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             fresh_ff, fresh_in;
   logic [LEN_W-1:0] row_ff, row_in;
   logic             ovf_ff, ovf_in;
   logic [LEN_W-1:0] flight_ff, flight_in;
   logic             is_cmp;
   logic             issue;
   logic             row_over;
   logic [LEN_W-1:0] wr_idx;

   always_comb begin
      is_cmp   = in_op_ff == OP_COMPARE;
      // loads wait until no row is in flight, so every row sees one string
      issue    = in_full_ff && (is_cmp ? advance : (flight_ff == '0));
      row_over = row_ff >= LEN_W'(MAX_LEN);
      wr_idx   = fresh_ff ? '0 : len_ff;

      len_in   = len_ff;
      fresh_in = fresh_ff;
      row_in   = row_ff;
      ovf_in   = ovf_ff;

      store_wr.we  = 1'b0;
      store_wr.idx = wr_idx[IDX_W-1:0];
      store_wr.sym = in_sym_ff;

      wave_o.valid = 1'b0;
      wave_o.proc  = !row_over;
      wave_o.last  = in_last_ff;
      wave_o.ovf   = ovf_ff | row_over;
      wave_o.sym   = in_sym_ff;
      wave_o.diag  = '0;
      wave_o.best  = '0;

      if (issue) begin
         if (!is_cmp) begin
            fresh_in = in_last_ff;
            if (wr_idx < LEN_W'(MAX_LEN)) begin
               store_wr.we = 1'b1;
               len_in      = wr_idx + 1'b1;
            end else begin
               len_in = wr_idx;
               ovf_in = 1'b1;
            end
         end else begin
            if (row_over) begin
               ovf_in = 1'b1;
            end else begin
               row_in       = row_ff + 1'b1;
               wave_o.valid = 1'b1;
            end
            if (in_last_ff) begin
               // a last beat past the row limit still carries the result out
               wave_o.valid = 1'b1;
               row_in       = '0;
               ovf_in       = 1'b0;
            end
         end
      end

      flight_in = flight_ff;
      if (wave_o.valid && !chain_exit) begin
         flight_in = flight_ff + 1'b1;
      end else if (!wave_o.valid && chain_exit) begin
         flight_in = flight_ff - 1'b1;
      end

      req_tready = !in_full_ff || issue;
      in_full_in = in_full_ff;
      if (req_tvalid && req_tready) begin
         in_full_in = 1'b1;
      end else if (issue) begin
         in_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff <= 1'b0;
         len_ff     <= '0;
         fresh_ff   <= 1'b1;
         row_ff     <= '0;
         ovf_ff     <= 1'b0;
         flight_ff  <= '0;
      end else begin
         in_full_ff <= in_full_in;
         len_ff     <= len_in;
         fresh_ff   <= fresh_in;
         row_ff     <= row_in;
         ovf_ff     <= ovf_in;
         flight_ff  <= flight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_op;
         in_sym_ff  <= req_sym;
         in_last_ff <= req_last;
      end
   end

   assign str_len = len_ff;

endmodule
`default_nettype wire

[hdl/lcs_tail.sv]
// Chain exit: tracks the best row, forms the result and holds it for the output.
`default_nettype none
module lcs_tail (
   input  wire                  clock,
   input  wire                  reset,
   input  lcs_pkg::wave_type     wave_i,
   input  wire                  rsp_tready,
   output logic                 advance,
   output logic                 chain_exit,
   output logic                 rsp_valid,
   output logic [lcs_pkg::MATCH_LEN_W-1:0]   rsp_len,
   output logic [lcs_pkg::MATCH_START_W-1:0] rsp_start,
   output logic                 rsp_ovf
);
   import lcs_pkg::*;

   logic [LEN_W-1:0]         best_ff, best_new;
   logic [IDX_W-1:0]         end_ff, end_new;
   logic [IDX_W-1:0]         row_ff;
   logic [LEN_W-1:0]         start;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MATCH_LEN_W-1:0]   rsp_len_ff;
   logic [MATCH_START_W-1:0] rsp_start_ff;
   logic                     rsp_ovf_ff;
   logic                     done;

   always_comb begin
      advance    = !rsp_valid_ff || rsp_tready;
      chain_exit = wave_i.valid && advance;
      done       = chain_exit && wave_i.last;

      best_new = best_ff;
      end_new  = end_ff;
      // strictly longer only: ties stay with the earliest row
      if (wave_i.proc && (wave_i.best > best_ff)) begin
         best_new = wave_i.best;
         end_new  = row_ff;
      end
      start = (best_new == '0) ? '0 : LEN_W'(end_new) + 1'b1 - best_new;

      rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         end_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (chain_exit) begin
            if (wave_i.last) begin
               best_ff <= '0;
               end_ff  <= '0;
               row_ff  <= '0;
            end else begin
               best_ff <= best_new;
               end_ff  <= end_new;
               if (wave_i.proc) begin
                  row_ff <= row_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_len_ff   <= MATCH_LEN_W'(best_new);
         rsp_start_ff <= MATCH_START_W'(start);
         rsp_ovf_ff   <= wave_i.ovf;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_len   = rsp_len_ff;
   assign rsp_start = rsp_start_ff;
   assign rsp_ovf   = rsp_ovf_ff;

endmodule
`default_nettype wire

[hdl/longest_common_substring_core.sv]
// Top level: input stage, systolic chain of column cells, result stage.
//
//   channel | ports | beat contents
//   request | req_* | tuser[0] opcode, tdata[7:0] symbol, tlast last
//   result  | rsp_* | tdata[10:0] match_length, tdata[20:11] match_start, tuser[0] overflow
//
// Compare beats are accepted one per cycle while no result waits on rsp_tready; each
// launches a row wave that crosses one column cell per cycle under the same condition,
// registered in each cell, and the result stage registers the result when the last row
// leaves the chain. A load beat waits until no row is in the chain, then is written.
// Reset is synchronous and clears all run lengths at once; no clearing pass.
// A result waiting on rsp_tready freezes the chain and the compare beats, not the load beats.
`default_nettype none
module longest_common_substring_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // [7:0] symbol
   input  wire [0:0]  req_tuser,   // [0] opcode
   input  wire        req_tlast,   // last
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [lcs_pkg::RSP_DATA_W-1:0] rsp_tdata, // [10:0] match_length, [20:11] match_start
   output logic [0:0] rsp_tuser    // [0] overflow
);
   import lcs_pkg::*;

   wave_type                 chain_w [MAX_LEN+1];
   store_wr_type             store_wr;
   logic [LEN_W-1:0]         str_len;
   logic                     advance;
   logic                     chain_exit;
   logic [MATCH_LEN_W-1:0]   rsp_len;
   logic [MATCH_START_W-1:0] rsp_start;
   logic                     rsp_ovf;

   lcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser[0])),
      .req_sym    (req_tdata[SYM_W-1:0]),
      .req_last   (req_tlast),
      .advance    (advance),
      .chain_exit (chain_exit),
      .wave_o     (chain_w[0]),
      .store_wr   (store_wr),
      .str_len    (str_len)
   );

   for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
      lcs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(g)),
         .str_len    (str_len),
         .store_wr   (store_wr),
         .wave_i     (chain_w[g]),
         .wave_o     (chain_w[g+1])
      );
   end

   lcs_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .wave_i     (chain_w[MAX_LEN]),
      .rsp_tready (rsp_tready),
      .advance    (advance),
      .chain_exit (chain_exit),
      .rsp_valid  (rsp_tvalid),
      .rsp_len    (rsp_len),
      .rsp_start  (rsp_start),
      .rsp_ovf    (rsp_ovf)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_start, rsp_len});
   assign rsp_tuser = rsp_ovf;

endmodule
`default_nettype wire

[hdl/lcs_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module lcs_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [lcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire [0:0]  rsp_tuser
);
   import lcs_pkg::*;

   logic [MATCH_LEN_W-1:0]   len_w;
   logic [MATCH_START_W-1:0] start_w;

   assign len_w   = rsp_tdata[MATCH_LEN_W-1:0];
   assign start_w = rsp_tdata[MATCH_LEN_W+MATCH_START_W-1:MATCH_LEN_W];

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_empty_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (len_w == '0) |-> start_w == '0)
      else $error("zero length match with nonzero start");

   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(len_w) + 32'(start_w)) <= 32'(MAX_LEN))
      else $error("match runs past the end of the first string");

endmodule

bind longest_common_substring_core lcs_checker u_lcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
